// ----- src/lpm_pkg.sv -----
// ----------------------------------------------------------------------------
// lpm_pkg: shared types for the longest prefix match lookup unit
// Table depth, transaction payloads, the token that walks the cell chain and
// the prefix mask helper.
// ----------------------------------------------------------------------------
package lpm_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W      = 32;
  localparam int LEN_W       = 6;
  localparam int IFC_W       = 8;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_LOOKUP = 2'd2
  } lpm_op_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  prefix_length;
    logic [IFC_W-1:0]  interface_number;
  } lpm_item_t;

  typedef struct packed {
    logic [IFC_W-1:0] out_interface;
    logic [LEN_W-1:0] out_prefix_length;
    logic             matched;
    logic             no_route;
  } lpm_result_t;

  // Append: address/len/ifc are the route, cnt is the target slot.
  // Lookup: address is the key, len/ifc hold the default (last) route,
  // cnt is the number of live routes when the lookup entered.
  typedef struct packed {
    logic              valid;
    logic              lookup;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  len;
    logic [IFC_W-1:0]  ifc;
    logic [CNT_W-1:0]  cnt;
    logic              found;
    logic [LEN_W-1:0]  best_len;
    logic [IFC_W-1:0]  best_ifc;
  } lpm_token_t;

  // Top len bits set; len is at most 32, so len 0 gives zero and 32 all ones.
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    prefix_mask = ~({ADDR_W{1'b1}} >> len);
  endfunction

endpackage

// ----- src/lpm_cell.sv -----
// ----------------------------------------------------------------------------
// lpm_cell: one route slot of the lookup chain
// Holds one route, captures an append aimed at its slot and folds its own
// match into a passing lookup.
// ----------------------------------------------------------------------------
module lpm_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     advance,
  input  logic [lpm_pkg::CNT_W-1:0] cell_index,
  input  lpm_pkg::lpm_token_t      tok_in,
  output lpm_pkg::lpm_token_t      tok_out
);
  import lpm_pkg::*;

  logic [ADDR_W-1:0] route_address;
  logic [LEN_W-1:0]  route_length;
  logic [IFC_W-1:0]  route_interface;

  logic       live;
  logic       hit;
  logic       write_en;
  lpm_token_t tok_next;

  assign live     = cell_index < tok_in.cnt;
  assign write_en = tok_in.valid && !tok_in.lookup && (tok_in.cnt == cell_index);
  assign hit      = tok_in.valid && tok_in.lookup && live &&
                    ((tok_in.address & prefix_mask(route_length)) == route_address);

  always_comb begin
    tok_next = tok_in;
    // strictly longer only, so the earliest route keeps a tie
    if (hit && (!tok_in.found || (route_length > tok_in.best_len))) begin
      tok_next.found    = 1'b1;
      tok_next.best_len = route_length;
      tok_next.best_ifc = route_interface;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && write_en) begin
      route_address   <= tok_in.address;
      route_length    <= tok_in.len;
      route_interface <= tok_in.ifc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (advance) begin
      tok_out <= tok_next;
    end
  end

endmodule

// ----- src/longest_prefix_match_lookup_unit.sv -----
// ----------------------------------------------------------------------------
// longest_prefix_match_lookup_unit: IPv4 longest prefix match table
// Lookup path: a lookup result passes one register per cell, the first one
//   loaded at the accepting edge, and is presented from the last cell.
// Throughput: one transaction per cycle; the whole chain freezes only while a
//   result is held by a stalled consumer.
// Reset: clears the route count and empties the chain; route slots are not
//   cleared and are never read before being written.
// ----------------------------------------------------------------------------
module longest_prefix_match_lookup_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  lpm_pkg::lpm_item_t   item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output lpm_pkg::lpm_result_t result
);
  import lpm_pkg::*;

  // Head state: number of live routes and a copy of the last appended route,
  // which is the default answer when no prefix matches.
  logic [CNT_W-1:0] route_count;
  logic [LEN_W-1:0] last_len;
  logic [IFC_W-1:0] last_ifc;

  logic             accept;
  logic             advance;
  logic             table_full;
  logic [LEN_W-1:0] sat_len;

  // chain[0] is the token entering cell 0; chain[k+1] is cell k's register.
  lpm_token_t chain [TABLE_DEPTH+1];
  lpm_token_t head_tok;
  lpm_token_t tail;

  assign chain[0]     = head_tok;
  assign tail         = chain[TABLE_DEPTH];
  assign result_valid = tail.valid && tail.lookup;
  // Appends drop off the end of the chain silently; only a pending lookup
  // result can hold the chain.
  assign advance      = !(result_valid && result_stall);
  assign item_stall   = !advance;
  assign accept       = item_valid && !item_stall;

  assign table_full = route_count == CNT_W'(TABLE_DEPTH);
  assign sat_len    = (item.prefix_length > MAX_LEN) ? MAX_LEN : item.prefix_length;

  // Build the entering token. Clears only touch the head count, so they
  // never enter the chain; neither do appends to a full table or opcode 3.
  always_comb begin
    head_tok          = '0;
    head_tok.lookup   = item.opcode == OP_LOOKUP;
    head_tok.address  = item.address;
    head_tok.cnt      = route_count;
    if (item.opcode == OP_LOOKUP) begin
      head_tok.valid = accept;
      head_tok.len   = last_len;
      head_tok.ifc   = last_ifc;
    end else begin
      head_tok.valid = accept && (item.opcode == OP_APPEND) && !table_full;
      head_tok.len   = sat_len;
      head_tok.ifc   = item.interface_number;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      route_count <= '0;
    end else if (accept) begin
      unique case (item.opcode)
        OP_CLEAR: begin
          route_count <= '0;
        end
        OP_APPEND: begin
          if (!table_full) begin
            route_count <= route_count + CNT_W'(1);
            last_len    <= sat_len;
            last_ifc    <= item.interface_number;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Row of route cells; slot k lives in cell k.
  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    lpm_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .advance    (advance),
      .cell_index (CNT_W'(k)),
      .tok_in     (chain[k]),
      .tok_out    (chain[k+1])
    );
  end

  // Final answer from the token leaving the last cell. An empty table
  // (count zero when the lookup entered) reports no_route with zero fields.
  always_comb begin
    result = '0;
    if (tail.cnt == '0) begin
      result.no_route = 1'b1;
    end else if (tail.found) begin
      result.out_interface     = tail.best_ifc;
      result.out_prefix_length = tail.best_len;
      result.matched           = 1'b1;
    end else begin
      result.out_interface     = tail.ifc;
      result.out_prefix_length = tail.len;
    end
  end

  // Route count never passes the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    route_count <= CNT_W'(TABLE_DEPTH))
    else $error("route count above table depth");

  // An accepted clear empties the table on the next cycle.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && (item.opcode == OP_CLEAR) |=> route_count == '0)
    else $error("clear did not empty the table");

  // A no-route answer carries all other fields at zero.
  a_no_route_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.no_route |->
      !result.matched && (result.out_interface == '0) &&
      (result.out_prefix_length == '0))
    else $error("no-route result with nonzero fields");

  // A valid answer never reports a prefix longer than 32.
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.out_prefix_length <= MAX_LEN)
    else $error("result prefix length out of range");

endmodule
